// ===== rtl/core/bced_pkg.sv =====
`default_nettype none
package bced_pkg;

  localparam int TICK_WIDTH = 16;
  localparam int LIMIT_WIDTH = 16;
  localparam int CMP_WIDTH = (TICK_WIDTH > LIMIT_WIDTH) ? TICK_WIDTH : LIMIT_WIDTH;
  localparam int DEB_WIDTH = 8;
  localparam int EVENT_WIDTH = 3;
  localparam int COUNT_WIDTH = 4;
  localparam int CFG_DATA_WIDTH = 16;
  localparam int CFG_INDEX_WIDTH = 3;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = COUNT_WIDTH'(15);
  localparam logic [COUNT_WIDTH-1:0] REPEAT_MAX_DEFAULT = COUNT_WIDTH'(2);
  localparam logic [TICK_WIDTH-1:0] TICK_MAX = {TICK_WIDTH{1'b1}};

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_DEBOUNCE_LIMIT = 3'd0,
    REG_SHORT_LIMIT    = 3'd1,
    REG_LONG_LIMIT     = 3'd2,
    REG_PRESSED_LEVEL  = 3'd3,
    REG_REPEAT_ENABLE  = 3'd4,
    REG_REPEAT_MAX     = 3'd5
  } bced_reg_t;

  typedef enum logic [EVENT_WIDTH-1:0] {
    EV_NONE          = 3'd0,
    EV_PRESSED       = 3'd1,
    EV_RELEASED      = 3'd2,
    EV_SINGLE        = 3'd3,
    EV_REPEAT        = 3'd4,
    EV_LONG          = 3'd5,
    EV_LONG_HOLD     = 3'd6,
    EV_LONG_RELEASED = 3'd7
  } bced_event_t;

  typedef enum logic [2:0] {
    ST_IDLE        = 3'd0,
    ST_DOWN        = 3'd1,
    ST_UP          = 3'd2,
    ST_REDOWN      = 3'd3,
    ST_LONG        = 3'd5,
    ST_REPEAT_DONE = 3'd6
  } bced_state_t;

  typedef struct packed {
    logic [DEB_WIDTH-1:0]   debounce_limit;
    logic [LIMIT_WIDTH-1:0] short_limit;
    logic [LIMIT_WIDTH-1:0] long_limit;
    logic                   pressed_level;
    logic                   repeat_enable;
    logic [COUNT_WIDTH-1:0] repeat_max;
  } bced_cfg_t;

  typedef struct packed {
    bced_event_t            event_code;
    logic [COUNT_WIDTH-1:0] click_count;
  } bced_result_t;

endpackage
`default_nettype wire

// ===== rtl/core/bced_debounce.sv =====
`default_nettype none
module bced_debounce
  import bced_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 step,
  input  wire logic                 raw_level,
  input  wire bced_cfg_t            cfg,
  output logic                      down_nxt
);

  logic                 pressed_r;
  logic [DEB_WIDTH-1:0] count_r;
  logic [DEB_WIDTH-1:0] count_nxt;
  logic [DEB_WIDTH:0]   count_inc;
  logic                 raw_pressed;

  always_comb begin
    raw_pressed = (raw_level == cfg.pressed_level);
    count_inc = {1'b0, count_r} + 1'b1;
    down_nxt = pressed_r;
    count_nxt = '0;
    if (raw_pressed != pressed_r) begin
      if (count_inc > {1'b0, cfg.debounce_limit}) begin
        down_nxt = raw_pressed;
      end else begin
        count_nxt = count_inc[DEB_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pressed_r <= 1'b0;
      count_r <= '0;
    end else if (step) begin
      pressed_r <= down_nxt;
      count_r <= count_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/bced_fsm.sv =====
`default_nettype none
module bced_fsm
  import bced_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         step,
  input  wire logic         down,
  input  wire bced_cfg_t    cfg,
  output bced_result_t      result_nxt
);

  bced_state_t            state_r, state_nxt;
  logic [TICK_WIDTH-1:0]  tick_r, tick_nxt, tick_inc;
  bced_event_t            event_r, event_nxt;
  logic [COUNT_WIDTH-1:0] press_r, press_nxt, press_inc;
  logic                   past_long, past_short, below_short, can_count, hit_max;

  always_comb begin
    tick_inc = ((state_r != ST_IDLE) && (tick_r != TICK_MAX)) ? tick_r + 1'b1 : tick_r;
    past_long = CMP_WIDTH'(tick_inc) > CMP_WIDTH'(cfg.long_limit);
    past_short = CMP_WIDTH'(tick_inc) > CMP_WIDTH'(cfg.short_limit);
    below_short = CMP_WIDTH'(tick_inc) < CMP_WIDTH'(cfg.short_limit);
    can_count = press_r < COUNT_MAX;
    press_inc = press_r + 1'b1;
    hit_max = can_count && (press_inc == cfg.repeat_max);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (down) state_nxt = ST_DOWN;
      end
      ST_DOWN: begin
        if (!down) state_nxt = ST_UP;
        else if (past_long) state_nxt = ST_LONG;
      end
      ST_UP: begin
        if (!cfg.repeat_enable) begin
          if (!down) state_nxt = ST_IDLE;
          else if (past_long) state_nxt = ST_LONG;
        end else if (down) begin
          state_nxt = hit_max ? ST_REPEAT_DONE : ST_REDOWN;
        end else if (past_short) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_REDOWN: begin
        if (!down) state_nxt = below_short ? ST_UP : ST_IDLE;
        else if (past_long) state_nxt = ST_LONG;
      end
      ST_LONG: begin
        if (!down) state_nxt = ST_IDLE;
      end
      ST_REPEAT_DONE: begin
        if (!down) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    tick_nxt = tick_inc;
    event_nxt = event_r;
    press_nxt = press_r;
    unique case (state_r)
      ST_IDLE: begin
        if (down) begin
          event_nxt = EV_PRESSED;
          tick_nxt = '0;
          press_nxt = COUNT_WIDTH'(1);
        end else begin
          event_nxt = EV_NONE;
        end
      end
      ST_DOWN: begin
        if (!down) begin
          event_nxt = EV_RELEASED;
          tick_nxt = '0;
        end else if (past_long) begin
          event_nxt = EV_LONG;
        end
      end
      ST_UP: begin
        if (!cfg.repeat_enable) begin
          if (!down) event_nxt = EV_SINGLE;
          else if (past_long) event_nxt = EV_LONG;
        end else if (down) begin
          tick_nxt = '0;
          event_nxt = hit_max ? EV_REPEAT : EV_PRESSED;
          if (can_count) press_nxt = press_inc;
        end else if (past_short) begin
          event_nxt = (press_r == COUNT_WIDTH'(1)) ? EV_SINGLE : EV_REPEAT;
        end
      end
      ST_REDOWN: begin
        if (!down) begin
          event_nxt = EV_RELEASED;
          if (below_short) tick_nxt = '0;
        end else if (past_long) begin
          event_nxt = EV_LONG;
        end
      end
      ST_LONG: begin
        event_nxt = down ? EV_LONG_HOLD : EV_LONG_RELEASED;
      end
      ST_REPEAT_DONE: begin
        event_nxt = EV_NONE;
      end
      default: begin
        tick_nxt = tick_r;
      end
    endcase
  end

  assign result_nxt.event_code = event_nxt;
  assign result_nxt.click_count = press_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      tick_r <= '0;
      event_r <= EV_NONE;
      press_r <= '0;
    end else if (step) begin
      state_r <= state_nxt;
      tick_r <= tick_nxt;
      event_r <= event_nxt;
      press_r <= press_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/button_click_event_detector.sv =====
`default_nettype none
// Button click detector: each input word is one timer tick carrying the raw pin
// level, and each tick gives exactly one output word with the current event code
// and the click count of the current sequence. A new tick is taken every cycle unless
// in_stall is high; a tick passes through an input register and the debounce and
// state-machine update into the output register when the output is not stalled. A
// stalled output holds its word while one more tick waits in the input register;
// further input is stalled only then. The user must write registers through
// cfg_wr_en/cfg_index/cfg_data while no tick is in flight, which the block does not
// enforce; repeat_max written as zero reads as 2, and unknown indexes are ignored.
module button_click_event_detector
  import bced_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic                       in_raw_level,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [EVENT_WIDTH-1:0]          out_event_code,
  output logic [COUNT_WIDTH-1:0]          out_click_count,
  input  wire logic                       cfg_wr_en,
  input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

  bced_cfg_t              cfg_r;
  logic                   in_valid_r;
  logic                   pin_r;
  logic                   out_valid_r;
  logic [EVENT_WIDTH-1:0] event_r;
  logic [COUNT_WIDTH-1:0] count_r;
  logic                   step;
  logic                   down;
  bced_result_t           result;
  logic [COUNT_WIDTH-1:0] rep_max;

  assign step = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !step;
  assign rep_max = (cfg_data[COUNT_WIDTH-1:0] == '0) ? REPEAT_MAX_DEFAULT
                                                      : cfg_data[COUNT_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_limit <= DEB_WIDTH'(3);
      cfg_r.short_limit <= LIMIT_WIDTH'(60);
      cfg_r.long_limit <= LIMIT_WIDTH'(200);
      cfg_r.pressed_level <= 1'b0;
      cfg_r.repeat_enable <= 1'b0;
      cfg_r.repeat_max <= REPEAT_MAX_DEFAULT;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_DEBOUNCE_LIMIT: cfg_r.debounce_limit <= cfg_data[DEB_WIDTH-1:0];
        REG_SHORT_LIMIT:    cfg_r.short_limit <= cfg_data[LIMIT_WIDTH-1:0];
        REG_LONG_LIMIT:     cfg_r.long_limit <= cfg_data[LIMIT_WIDTH-1:0];
        REG_PRESSED_LEVEL:  cfg_r.pressed_level <= cfg_data[0];
        REG_REPEAT_ENABLE:  cfg_r.repeat_enable <= cfg_data[0];
        REG_REPEAT_MAX:     cfg_r.repeat_max <= rep_max;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) in_valid_r <= in_valid;
      if (step) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) pin_r <= in_raw_level;
    if (step) begin
      event_r <= result.event_code;
      count_r <= result.click_count;
    end
  end

  bced_debounce u_debounce (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .raw_level (pin_r),
    .cfg       (cfg_r),
    .down_nxt  (down)
  );

  bced_fsm u_fsm (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .down       (down),
    .cfg        (cfg_r),
    .result_nxt (result)
  );

  assign out_valid = out_valid_r;
  assign out_event_code = event_r;
  assign out_click_count = count_r;

endmodule
`default_nettype wire

// ===== tb/tb_button_click_event_detector.sv =====
`timescale 1ns / 100ps

module tb_button_click_event_detector;
  import bced_pkg::*;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNUSED = 3'd7;

  typedef struct {
    bit                         is_cfg;
    logic [CFG_INDEX_WIDTH-1:0] idx;
    logic [CFG_DATA_WIDTH-1:0]  data;
    bit                         lvl;
    bit                         typed;
    bced_result_t               want;
  } script_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic in_raw_level;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [EVENT_WIDTH-1:0] out_event_code;
  logic [COUNT_WIDTH-1:0] out_click_count;
  logic cfg_wr_en;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [CFG_DATA_WIDTH-1:0] cfg_data;

  // register shadow
  logic [DEB_WIDTH-1:0]   c_debounce;
  logic [LIMIT_WIDTH-1:0] c_short;
  logic [LIMIT_WIDTH-1:0] c_long;
  bit                     c_active;
  bit                     c_repeat;
  logic [COUNT_WIDTH-1:0] c_rmax;

  // button state shadow
  bced_state_t            btn_state;
  logic [TICK_WIDTH-1:0]  hold_ticks;
  logic [DEB_WIDTH-1:0]   bounce_cnt;
  bit                     level_down;
  bced_event_t            last_event;
  logic [COUNT_WIDTH-1:0] clicks;

  bced_result_t expected_words[$];
  script_row_t  script[$];
  bced_result_t head_word;

  int gap_pct = 0;
  int stall_pct = 0;
  int errors = 0;
  int n_ticks = 0;
  int n_words = 0;
  int n_settings = 0;
  bit in_flight = 1'b0;

  button_click_event_detector dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_raw_level    (in_raw_level),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_event_code  (out_event_code),
    .out_click_count (out_click_count),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #2 clk = ~clk;

  function automatic void reset_shadow();
    c_debounce = 8'd3;
    c_short    = 16'd60;
    c_long     = 16'd200;
    c_active   = 1'b0;
    c_repeat   = 1'b0;
    c_rmax     = REPEAT_MAX_DEFAULT;
    btn_state  = ST_IDLE;
    hold_ticks = '0;
    bounce_cnt = '0;
    level_down = 1'b0;
    last_event = EV_NONE;
    clicks     = '0;
  endfunction

  function automatic void apply_cfg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                                    input logic [CFG_DATA_WIDTH-1:0] v);
    case (idx)
      REG_DEBOUNCE_LIMIT: c_debounce = v[DEB_WIDTH-1:0];
      REG_SHORT_LIMIT:    c_short = v[LIMIT_WIDTH-1:0];
      REG_LONG_LIMIT:     c_long = v[LIMIT_WIDTH-1:0];
      REG_PRESSED_LEVEL:  c_active = v[0];
      REG_REPEAT_ENABLE:  c_repeat = v[0];
      REG_REPEAT_MAX: begin
        c_rmax = v[COUNT_WIDTH-1:0];
        if (c_rmax == '0) c_rmax = REPEAT_MAX_DEFAULT;
      end
      default: ;
    endcase
  endfunction

  function automatic bced_result_t predict_tick(input bit lvl);
    bit raw_down;
    logic [DEB_WIDTH:0] bounce_next;
    bced_result_t r;
    raw_down = (lvl == c_active);
    if (btn_state != ST_IDLE && hold_ticks != TICK_MAX) hold_ticks = hold_ticks + 1'b1;
    if (raw_down != level_down) begin
      bounce_next = {1'b0, bounce_cnt} + 1'b1;
      if (bounce_next > {1'b0, c_debounce}) begin
        level_down = raw_down;
        bounce_cnt = '0;
      end else begin
        bounce_cnt = bounce_next[DEB_WIDTH-1:0];
      end
    end else begin
      bounce_cnt = '0;
    end
    case (btn_state)
      ST_IDLE: begin
        if (level_down) begin
          last_event = EV_PRESSED;
          hold_ticks = '0;
          clicks = 4'd1;
          btn_state = ST_DOWN;
        end else begin
          last_event = EV_NONE;
        end
      end
      ST_DOWN: begin
        if (!level_down) begin
          last_event = EV_RELEASED;
          hold_ticks = '0;
          btn_state = ST_UP;
        end else if (hold_ticks > c_long) begin
          last_event = EV_LONG;
          btn_state = ST_LONG;
        end
      end
      ST_UP: begin
        if (!c_repeat) begin
          if (!level_down) begin
            last_event = EV_SINGLE;
            btn_state = ST_IDLE;
          end else if (hold_ticks > c_long) begin
            last_event = EV_LONG;
            btn_state = ST_LONG;
          end
        end else if (level_down) begin
          last_event = EV_PRESSED;
          hold_ticks = '0;
          btn_state = ST_REDOWN;
          if (clicks < COUNT_MAX) begin
            clicks = clicks + 1'b1;
            if (clicks == c_rmax) begin
              last_event = EV_REPEAT;
              btn_state = ST_REPEAT_DONE;
            end
          end
        end else if (hold_ticks > c_short) begin
          last_event = (clicks == 4'd1) ? EV_SINGLE : EV_REPEAT;
          btn_state = ST_IDLE;
        end
      end
      ST_REDOWN: begin
        if (!level_down) begin
          last_event = EV_RELEASED;
          if (hold_ticks < c_short) begin
            hold_ticks = '0;
            btn_state = ST_UP;
          end else begin
            btn_state = ST_IDLE;
          end
        end else if (hold_ticks > c_long) begin
          last_event = EV_LONG;
          btn_state = ST_LONG;
        end
      end
      ST_LONG: begin
        if (level_down) begin
          last_event = EV_LONG_HOLD;
        end else begin
          last_event = EV_LONG_RELEASED;
          btn_state = ST_IDLE;
        end
      end
      ST_REPEAT_DONE: begin
        last_event = EV_NONE;
        if (!level_down) btn_state = ST_IDLE;
      end
      default: btn_state = ST_IDLE;
    endcase
    r.event_code = last_event;
    r.click_count = clicks;
    return r;
  endfunction

  task automatic send_tick(input bit lvl, input bit typed, input bced_result_t want);
    bced_result_t pred;
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_raw_level <= lvl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = predict_tick(lvl);
    expected_words.push_back(typed ? want : pred);
    in_flight = 1'b1;
    n_ticks++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    in_flight = 1'b0;
  endtask

  task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                           input logic [CFG_DATA_WIDTH-1:0] v);
    if (in_flight) settle();
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    apply_cfg(idx, v);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic add_row(input bit is_cfg, input logic [CFG_INDEX_WIDTH-1:0] idx,
                         input logic [CFG_DATA_WIDTH-1:0] data, input bit lvl,
                         input bit typed, input bced_event_t ev,
                         input logic [COUNT_WIDTH-1:0] cnt);
    script_row_t r;
    r.is_cfg = is_cfg;
    r.idx = idx;
    r.data = data;
    r.lvl = lvl;
    r.typed = typed;
    r.want.event_code = ev;
    r.want.click_count = cnt;
    script.push_back(r);
  endtask

  task automatic cfg_row(input logic [CFG_INDEX_WIDTH-1:0] idx,
                         input logic [CFG_DATA_WIDTH-1:0] data);
    add_row(1'b1, idx, data, 1'b0, 1'b0, EV_NONE, '0);
  endtask

  task automatic tick_row(input bit lvl);
    add_row(1'b0, '0, '0, lvl, 1'b0, EV_NONE, '0);
  endtask

  task automatic hold_level(input bit pressed, input int n, input int noise_pct);
    bit lvl;
    for (int i = 0; i < n; i++) begin
      lvl = pressed ? c_active : ~c_active;
      if ($urandom_range(0, 99) < noise_pct) lvl = ~lvl;
      send_tick(lvl, 1'b0, '0);
    end
  endtask

  task automatic run_gesture();
    int kind;
    int pad;
    int reps;
    kind = $urandom_range(0, 9);
    pad = (c_debounce == 8'hff) ? 0 : int'(c_debounce);
    case (kind)
      0, 1, 2, 3: begin
        hold_level(1'b1, pad + $urandom_range(1, int'(c_long) + 2), 5);
        hold_level(1'b0, pad + $urandom_range(1, int'(c_short) + 4), 5);
      end
      4, 5: begin
        // fast multi-click burst
        reps = $urandom_range(2, 18);
        for (int i = 0; i < reps; i++) begin
          hold_level(1'b1, pad + $urandom_range(1, 2), 0);
          hold_level(1'b0, pad + $urandom_range(1, 2), 0);
        end
        hold_level(1'b0, pad + int'(c_short) + 3, 0);
      end
      6, 7: begin
        hold_level(1'b1, pad + int'(c_long) + $urandom_range(2, 8), 3);
        hold_level(1'b0, pad + $urandom_range(1, 6), 3);
      end
      8: begin
        reps = $urandom_range(1, 8);
        for (int i = 0; i < reps; i++) send_tick(1'($urandom_range(0, 1)), 1'b0, '0);
      end
      default: begin
        // heavy bounce
        hold_level(1'b1, pad + $urandom_range(1, 6), 30);
        hold_level(1'b0, pad + $urandom_range(1, 6), 30);
      end
    endcase
  endtask

  always @(posedge clk) out_stall <= ($urandom_range(0, 99) < stall_pct);

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      n_words++;
      if (expected_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected word event %0d count %0d", $time, out_event_code,
                 out_click_count);
      end else begin
        head_word = expected_words.pop_front();
        if (out_event_code !== head_word.event_code) begin
          errors++;
          $display("%0t: event_code expected %0d got %0d", $time, head_word.event_code,
                   out_event_code);
        end
        if (out_click_count !== head_word.click_count) begin
          errors++;
          $display("%0t: click_count expected %0d got %0d", $time, head_word.click_count,
                   out_click_count);
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

  initial begin
    int start;
    int deb;
    int shrt;
    int lng;
    int rmx;
    bit act;
    bit ren;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_raw_level = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    reset_shadow();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    gap_pct = 13;
    stall_pct = 47;

    // directed: pressed is pin low until the active level flips
    add_row(1'b0, '0, '0, 1'b1, 1'b1, EV_NONE, 4'd0);
    cfg_row(REG_DEBOUNCE_LIMIT, 16'd0);
    cfg_row(REG_SHORT_LIMIT, 16'd2);
    cfg_row(REG_LONG_LIMIT, 16'd3);
    add_row(1'b0, '0, '0, 1'b0, 1'b1, EV_PRESSED, 4'd1);
    add_row(1'b0, '0, '0, 1'b1, 1'b1, EV_RELEASED, 4'd1);
    add_row(1'b0, '0, '0, 1'b1, 1'b1, EV_SINGLE, 4'd1);
    repeat (6) tick_row(1'b0);
    tick_row(1'b1);
    cfg_row(REG_UNUSED, 16'hffff);
    cfg_row(REG_REPEAT_ENABLE, 16'd1);
    cfg_row(REG_REPEAT_MAX, 16'd0);
    tick_row(1'b0);
    tick_row(1'b1);
    add_row(1'b0, '0, '0, 1'b0, 1'b1, EV_REPEAT, 4'd2);
    tick_row(1'b1);
    cfg_row(REG_REPEAT_MAX, 16'd1);
    tick_row(1'b0);
    tick_row(1'b1);
    tick_row(1'b0);
    repeat (4) tick_row(1'b1);
    cfg_row(REG_DEBOUNCE_LIMIT, 16'd255);
    repeat (2) tick_row(1'b0);
    cfg_row(REG_PRESSED_LEVEL, 16'd1);
    cfg_row(REG_DEBOUNCE_LIMIT, 16'd0);
    add_row(1'b0, '0, '0, 1'b1, 1'b1, EV_PRESSED, 4'd1);
    tick_row(1'b0);

    foreach (script[i]) begin
      if (script[i].is_cfg) write_reg(script[i].idx, script[i].data);
      else send_tick(script[i].lvl, script[i].typed, script[i].want);
    end

    for (int s = 0; s < 12; s++) begin
      if (s < 4) begin
        gap_pct = 13;
        stall_pct = 47;
      end else if (s < 8) begin
        gap_pct = 47;
        stall_pct = 13;
      end else begin
        gap_pct = 0;
        stall_pct = 0;
      end
      deb = $urandom_range(0, 3);
      shrt = $urandom_range(0, 20);
      lng = $urandom_range(0, 40);
      act = 1'($urandom_range(0, 1));
      ren = 1'($urandom_range(0, 1));
      rmx = $urandom_range(0, 15);
      if (s % 4 == 1) begin
        // count saturates at fifteen
        deb = 0;
        shrt = $urandom_range(6, 12);
        ren = 1;
        rmx = 1;
      end
      if (s == 2) begin
        deb = 0;
        shrt = 0;
        lng = 0;
      end
      if (s == 3) deb = 255;
      if (s == 5) begin
        ren = 1;
        rmx = 15;
      end
      write_reg(REG_DEBOUNCE_LIMIT, CFG_DATA_WIDTH'(deb));
      write_reg(REG_SHORT_LIMIT, CFG_DATA_WIDTH'(shrt));
      write_reg(REG_LONG_LIMIT, CFG_DATA_WIDTH'(lng));
      write_reg(REG_PRESSED_LEVEL, CFG_DATA_WIDTH'(act));
      write_reg(REG_REPEAT_ENABLE, CFG_DATA_WIDTH'(ren));
      write_reg(REG_REPEAT_MAX, CFG_DATA_WIDTH'(rmx));
      n_settings++;
      start = n_ticks;
      run_gesture();
      if (s % 2 == 0) settle();
      while (n_ticks - start < 60) run_gesture();
    end

    settle();
    repeat (8) @(posedge clk);
    $display("ran %0d ticks under %0d random register settings plus directed rows",
             n_ticks, n_settings);
    $display("checked %0d output words, %0d mismatches", n_words, errors);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/bced_pkg.sv
rtl/core/bced_debounce.sv
rtl/core/bced_fsm.sv
rtl/core/button_click_event_detector.sv
tb/tb_button_click_event_detector.sv
